FILE: hw/rtl/erm_pkg.sv
`timescale 1ns / 1ps
package erm_pkg;

    localparam int KIND_W  = 2;
    localparam int TS_W    = 48;
    localparam int WIN_W   = 16;
    localparam int TPS_W   = 32;
    localparam int CNT_W   = 32;
    localparam int RATE_W  = 48;
    localparam int PROD_W  = 64;
    localparam int FRAC_W  = 16;
    localparam int NUM_W   = PROD_W + FRAC_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [TS_W-1:0]   t_ts;
    typedef logic [WIN_W-1:0]  t_win;
    typedef logic [TPS_W-1:0]  t_tps;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [RATE_W-1:0] t_rate;

    localparam t_kind KIND_EVENT   = 2'd0;
    localparam t_kind KIND_QUERY   = 2'd1;
    localparam t_kind KIND_RESTART = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_TPS = 1'b0;

    localparam t_tps  TPS_RESET = 32'd1000000;
    localparam t_rate RATE_MAX  = '1;
    localparam t_cnt  CNT_MAX   = '1;

    typedef logic [1:0] t_dsel;
    localparam t_dsel DSEL_EVENT  = 2'd0;
    localparam t_dsel DSEL_WINDOW = 2'd1;
    localparam t_dsel DSEL_TOTAL  = 2'd2;

    typedef struct packed {
        logic  accept;
        logic  span_calc;
        logic  scan_init;
        logic  scan_rd;
        logic  scan_cmp;
        logic  div_start;
        t_dsel div_sel;
        logic  cap_main;
        logic  cap_total;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  win_nz;
        logic  count_nz;
        logic  scan_stop;
        logic  div_busy;
        logic  div_done;
    } t_stat;

endpackage

FILE: hw/rtl/erm_if.sv
`timescale 1ns / 1ps
interface erm_in_if;
    import erm_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_ts   timestamp;
    t_win  window_seconds;

    modport source (output valid, output kind, output timestamp, output window_seconds,
                    input ready);
    modport sink   (input valid, input kind, input timestamp, input window_seconds,
                    output ready);
endinterface

interface erm_out_if;
    import erm_pkg::*;

    logic  valid;
    logic  ready;
    t_kind done_kind;
    t_rate instant_rate;
    logic  instant_infinite;
    t_rate window_rate;
    t_rate total_rate;
    logic  rate_saturated;

    modport source (output valid, output done_kind, output instant_rate,
                    output instant_infinite, output window_rate, output total_rate,
                    output rate_saturated, input ready);
    modport sink   (input valid, input done_kind, input instant_rate,
                    input instant_infinite, input window_rate, input total_rate,
                    input rate_saturated, output ready);
endinterface

FILE: hw/rtl/event_rate_meter_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake        Payload
// i_in      sink       valid / ready    kind, timestamp, window_seconds
// o_out     source     valid / ready    done_kind, instant_rate, instant_infinite,
//                                       window_rate, total_rate, rate_saturated
// apb       slave      psel / penable   ticks_per_second at address 0
//
// One request at a time: a new one is accepted only once the last is finished.
// Restart and unused kinds and a query with no events need no division; an event needs one.
// A query with events scans up to RECORD_DEPTH ring entries, with a ring read and a
// compare per entry, then runs two 80-step divisions (only one with a zero window)
// at one quotient bit per cycle in the shared divider.
// Synchronous active-low reset; the ring holds no reset and needs no clearing.
// The output register lets a new request be accepted while a result waits.
module event_rate_meter_top #(
    parameter int RECORD_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    erm_in_if.sink                          i_in,
    erm_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [erm_pkg::PADDR_W-1:0]     paddr,
    input  logic [erm_pkg::PDATA_W-1:0]     pwdata,
    output logic [erm_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import erm_pkg::*;

    t_tps  r_tps;
    logic  w_cfg_wr;
    logic  w_reg_sel;
    t_cmd  w_cmd;
    t_stat w_stat;

    assign w_reg_sel = paddr[PADDR_W-1];
    assign w_cfg_wr  = psel && penable && pwrite && (w_reg_sel == REG_TPS);
    assign pready    = 1'b1;
    assign prdata    = (w_reg_sel == REG_TPS) ? r_tps : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (w_cfg_wr) begin
            r_tps <= pwdata;
        end
    end

    erm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    erm_dpath #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_tps              (r_tps),
        .i_kind             (i_in.kind),
        .i_ts               (i_in.timestamp),
        .i_win              (i_in.window_seconds),
        .o_done_kind        (o_out.done_kind),
        .o_instant_rate     (o_out.instant_rate),
        .o_instant_infinite (o_out.instant_infinite),
        .o_window_rate      (o_out.window_rate),
        .o_total_rate       (o_out.total_rate),
        .o_rate_saturated   (o_out.rate_saturated)
    );

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over an untaken result");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider started while busy");

    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !w_stat.div_busy)
        else $error("request accepted while divider busy");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_tps == $past(pwdata)))
        else $error("ticks_per_second write lost");
endmodule

FILE: hw/rtl/erm_ram.sv
`timescale 1ns / 1ps
module erm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/erm_div.sv
`timescale 1ns / 1ps
module erm_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  erm_pkg::t_tps  i_a,
    input  erm_pkg::t_tps  i_b,
    input  erm_pkg::t_ts   i_d,
    output logic           o_busy,
    output logic           o_done,
    output erm_pkg::t_rate o_quot,
    output logic           o_sat
);
    import erm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);
    // quotient bits above the 48-bit result come out in the first steps
    localparam logic [STEP_W-1:0] OVF_STEPS = STEP_W'(NUM_W - RATE_W);

    logic [1:0]        r_phase;
    logic [STEP_W-1:0] r_step;
    logic              r_done;

    t_tps             r_a;
    t_tps             r_b;
    t_ts              r_d;
    logic [NUM_W-1:0] r_num;
    t_ts              r_rem;
    t_rate            r_q;
    logic             r_over;

    logic [PROD_W-1:0] w_prod;
    logic [TS_W:0]     w_shift;
    logic [TS_W:0]     w_diff;
    logic              w_ge;

    assign w_prod  = PROD_W'(r_a) * PROD_W'(r_b);
    assign w_shift = {r_rem, r_num[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};
    assign w_ge    = (w_shift >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_MUL;
                    end
                end
                PH_MUL: begin
                    r_phase <= PH_DIV;
                    r_step  <= '0;
                end
                PH_DIV: begin
                    if (r_step == LAST_STEP) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end
                    r_step <= r_step + 1'b1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_d <= i_d;
        end
        if (r_phase == PH_MUL) begin
            r_num  <= {w_prod, FRAC_W'(0)};
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end
        if (r_phase == PH_DIV) begin
            r_num <= r_num << 1;
            r_rem <= w_ge ? w_diff[TS_W-1:0] : w_shift[TS_W-1:0];
            r_q   <= {r_q[RATE_W-2:0], w_ge};
            if (w_ge && (r_step < OVF_STEPS)) begin
                r_over <= 1'b1;
            end
        end
    end

    assign o_busy = (r_phase != PH_IDLE);
    assign o_done = r_done;
    assign o_sat  = r_over || (r_d == '0);
    assign o_quot = o_sat ? RATE_MAX : r_q;
endmodule

FILE: hw/rtl/erm_dpath.sv
`timescale 1ns / 1ps
module erm_dpath #(
    parameter int RECORD_DEPTH = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  erm_pkg::t_cmd  i_cmd,
    output erm_pkg::t_stat o_stat,
    input  erm_pkg::t_tps  i_tps,
    input  erm_pkg::t_kind i_kind,
    input  erm_pkg::t_ts   i_ts,
    input  erm_pkg::t_win  i_win,
    output erm_pkg::t_kind o_done_kind,
    output erm_pkg::t_rate o_instant_rate,
    output logic           o_instant_infinite,
    output erm_pkg::t_rate o_window_rate,
    output erm_pkg::t_rate o_total_rate,
    output logic           o_rate_saturated
);
    import erm_pkg::*;

    localparam int AW = $clog2(RECORD_DEPTH);
    localparam int CW = $clog2(RECORD_DEPTH + 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(RECORD_DEPTH - 1);

    // architectural state
    t_ts           r_start_time;
    t_ts           r_last_time;
    t_cnt          r_count;
    logic [AW-1:0] r_wslot;

    // per-request working registers
    t_kind         r_kind;
    t_ts           r_ts;
    t_win          r_win;
    t_ts           r_gap;
    logic          r_inf;
    t_ts           r_ts_start;
    t_ts           r_span;
    t_ts           r_limit;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_scan_cnt;
    logic [CW-1:0] r_max_rec;
    logic [CW-1:0] r_records;
    t_ts           r_last_diff;
    t_rate         r_res_main;
    t_rate         r_res_total;
    logic          r_sat;

    t_kind r_o_kind;
    t_rate r_o_instant;
    logic  r_o_inf;
    t_rate r_o_window;
    t_rate r_o_total;
    logic  r_o_sat;

    logic          w_ring_we;
    logic [AW-1:0] w_idx_prev;
    t_ts           w_rdata;
    logic          w_hit;
    t_ts           w_lim_raw;
    logic          w_lim_clamp;

    t_tps  w_div_a;
    t_tps  w_div_b;
    t_ts   w_div_d;
    logic  w_div_busy;
    logic  w_div_done;
    t_rate w_div_quot;
    logic  w_div_sat;

    assign w_ring_we   = i_cmd.accept && (i_kind == KIND_EVENT);
    assign w_idx_prev  = (r_idx == '0) ? SLOT_LAST : r_idx - 1'b1;
    assign w_hit       = (w_rdata <= r_limit);
    assign w_lim_raw   = r_ts - r_span;
    assign w_lim_clamp = (r_ts < r_span) || (w_lim_raw < r_start_time);

    erm_ram #(
        .WIDTH (TS_W),
        .DEPTH (RECORD_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ring_we),
        .i_waddr (r_wslot),
        .i_wdata (i_ts),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (w_idx_prev),
        .o_rdata (w_rdata)
    );

    always_comb begin
        unique case (i_cmd.div_sel)
            DSEL_EVENT: begin
                w_div_a = i_tps;
                w_div_b = TPS_W'(1);
                w_div_d = r_gap;
            end
            DSEL_WINDOW: begin
                w_div_a = TPS_W'(r_records);
                w_div_b = i_tps;
                w_div_d = r_last_diff;
            end
            DSEL_TOTAL: begin
                w_div_a = r_count;
                w_div_b = i_tps;
                w_div_d = r_ts_start;
            end
            default: begin
                w_div_a = '0;
                w_div_b = '0;
                w_div_d = '0;
            end
        endcase
    end

    erm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (w_div_a),
        .i_b     (w_div_b),
        .i_d     (w_div_d),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot),
        .o_sat   (w_div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time <= '0;
            r_last_time  <= '0;
            r_count      <= '0;
            r_wslot      <= '0;
        end else if (i_cmd.accept) begin
            unique case (i_kind)
                KIND_EVENT: begin
                    r_last_time <= i_ts;
                    if (r_count != CNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_wslot <= (r_wslot == SLOT_LAST) ? '0 : r_wslot + 1'b1;
                end
                KIND_RESTART: begin
                    r_start_time <= i_ts;
                    r_last_time  <= i_ts;
                    r_count      <= '0;
                    r_wslot      <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind      <= i_kind;
            r_ts        <= i_ts;
            r_win       <= i_win;
            r_gap       <= i_ts - r_last_time;
            r_inf       <= (i_ts == r_last_time);
            r_ts_start  <= i_ts - r_start_time;
            r_res_main  <= '0;
            r_res_total <= '0;
            r_sat       <= 1'b0;
        end
        if (i_cmd.span_calc) begin
            r_span <= TS_W'(r_win) * TS_W'(i_tps);
        end
        if (i_cmd.scan_init) begin
            r_limit    <= w_lim_clamp ? r_start_time : w_lim_raw;
            r_idx      <= r_wslot;
            r_scan_cnt <= '0;
            r_records  <= '0;
            r_max_rec  <= (r_count < CNT_W'(RECORD_DEPTH)) ? r_count[CW-1:0]
                                                             : CW'(RECORD_DEPTH);
        end
        if (i_cmd.scan_rd) begin
            r_idx      <= w_idx_prev;
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (i_cmd.scan_cmp) begin
            if (!w_hit) begin
                r_records <= r_records + 1'b1;
            end
            // divisor quirk: span ends at the last entry visited
            r_last_diff <= r_ts - w_rdata;
        end
        if (i_cmd.cap_main) begin
            r_res_main <= w_div_quot;
            r_sat      <= r_sat | w_div_sat;
        end
        if (i_cmd.cap_total) begin
            r_res_total <= w_div_quot;
            r_sat       <= r_sat | w_div_sat;
        end
        if (i_cmd.load_out) begin
            r_o_kind    <= r_kind;
            r_o_instant <= (r_kind == KIND_EVENT) ? r_res_main : '0;
            r_o_inf     <= (r_kind == KIND_EVENT) && r_inf;
            r_o_window  <= (r_kind == KIND_QUERY) ? r_res_main : '0;
            r_o_total   <= (r_kind == KIND_QUERY) ? r_res_total : '0;
            r_o_sat     <= r_sat;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.win_nz    = (r_win != '0);
    assign o_stat.count_nz  = (r_count != '0);
    assign o_stat.scan_stop = w_hit || (r_scan_cnt == r_max_rec);
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.div_done  = w_div_done;

    assign o_done_kind        = r_o_kind;
    assign o_instant_rate     = r_o_instant;
    assign o_instant_infinite = r_o_inf;
    assign o_window_rate      = r_o_window;
    assign o_total_rate       = r_o_total;
    assign o_rate_saturated   = r_o_sat;
endmodule

FILE: hw/rtl/erm_ctrl.sv
`timescale 1ns / 1ps
module erm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output erm_pkg::t_cmd  o_cmd,
    input  erm_pkg::t_stat i_stat
);
    import erm_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DISPATCH = 4'd1;
    localparam logic [3:0] S_EV_WAIT  = 4'd2;
    localparam logic [3:0] S_Q_CHK    = 4'd3;
    localparam logic [3:0] S_Q_RD     = 4'd4;
    localparam logic [3:0] S_Q_CMP    = 4'd5;
    localparam logic [3:0] S_Q_WDIV   = 4'd6;
    localparam logic [3:0] S_Q_WWAIT  = 4'd7;
    localparam logic [3:0] S_Q_TDIV   = 4'd8;
    localparam logic [3:0] S_Q_TWAIT  = 4'd9;
    localparam logic [3:0] S_FIN      = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DSEL_EVENT;
        n_state       = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    KIND_EVENT: begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DSEL_EVENT;
                        n_state         = S_EV_WAIT;
                    end
                    KIND_QUERY: begin
                        o_cmd.span_calc = 1'b1;
                        n_state         = S_Q_CHK;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_EV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_main = 1'b1;
                    n_state        = S_FIN;
                end
            end
            S_Q_CHK: begin
                if (i_stat.win_nz && i_stat.count_nz) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_Q_RD;
                end else if (i_stat.count_nz) begin
                    n_state = S_Q_TDIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_Q_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_Q_CMP;
            end
            S_Q_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_stat.scan_stop ? S_Q_WDIV : S_Q_RD;
            end
            S_Q_WDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_WINDOW;
                n_state         = S_Q_WWAIT;
            end
            S_Q_WWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_main = 1'b1;
                    n_state        = S_Q_TDIV;
                end
            end
            S_Q_TDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DSEL_TOTAL;
                n_state         = S_Q_TWAIT;
            end
            S_Q_TWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_total = 1'b1;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import erm_pkg::*;

    localparam int          RING_DEPTH   = 64;
    localparam int          ITEM_TARGET  = 1700;
    localparam int          CYCLE_LIMIT  = 3000000;
    localparam int          TAIL_CYCLES  = 400;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD    = 1200;
    localparam int          MAX_IDLE     = 13;
    localparam t_kind       KIND_UNUSED  = 2'd3;
    localparam logic [PADDR_W-1:0] TPS_ADDR = {REG_TPS, 2'b00};
    localparam t_tps        TPS_MAX      = 32'hFFFF_FFFF;
    localparam t_ts         STAMP_MAX    = '1;

    typedef struct {
        t_kind kind;
        t_rate instant;
        logic  infinite;
        t_rate windowed;
        t_rate total;
        logic  saturated;
    } t_rate_result;

    logic clk;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    erm_in_if  in_if ();
    erm_out_if out_if ();

    event_rate_meter_top #(
        .RECORD_DEPTH(RING_DEPTH)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // meter state as seen by the predictor
    t_tps         tps_now;
    t_ts          meter_start;
    t_ts          meter_last;
    t_cnt         meter_count;
    int unsigned  meter_slot;
    t_ts          stamp_ring [RING_DEPTH];

    t_rate_result pending_results [$];
    int unsigned  mismatch_count;
    int unsigned  items_sent;
    int unsigned  out_hold_cycles;
    bit           idle_on;
    t_ts          stamp_now;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    function automatic int unsigned idle_draw();
        return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    endfunction

    function automatic t_ts rand_stamp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TS_W-1:0];
    endfunction

    // floor(a * b * 2^16 / d), clamped to the rate width
    function automatic t_rate scaled_rate(input logic [63:0] a, input logic [63:0] b,
                                          input t_ts d, inout logic sat);
        logic [63:0]       prod;
        logic [NUM_W-1:0]  num;
        logic [NUM_W-1:0]  quo;
        if (d == '0) begin
            sat = 1'b1;
            return RATE_MAX;
        end
        prod = a * b;
        num  = {prod, 16'h0000};
        quo  = num / {{(NUM_W-TS_W){1'b0}}, d};
        if (quo > {{(NUM_W-RATE_W){1'b0}}, RATE_MAX}) begin
            sat = 1'b1;
            return RATE_MAX;
        end
        return quo[RATE_W-1:0];
    endfunction

    function automatic void reset_meter();
        tps_now     = TPS_RESET;
        meter_start = '0;
        meter_last  = '0;
        meter_count = '0;
        meter_slot  = 0;
        foreach (stamp_ring[i]) stamp_ring[i] = '0;
    endfunction

    function automatic void predict_rates(input t_kind kind_in, input t_ts ts_in,
                                          input t_win win_in);
        t_rate_result r;
        logic         sat;
        t_ts          gap;
        t_ts          span;
        t_ts          scan_floor;
        t_ts          oldest_gap;
        int unsigned  n_scan;
        int unsigned  idx;
        int unsigned  hits;
        r.kind      = kind_in;
        r.instant   = '0;
        r.infinite  = 1'b0;
        r.windowed  = '0;
        r.total     = '0;
        sat         = 1'b0;
        case (kind_in)
            KIND_EVENT: begin
                gap = ts_in - meter_last;
                if (gap == '0) begin
                    r.instant  = RATE_MAX;
                    r.infinite = 1'b1;
                    sat        = 1'b1;
                end else begin
                    r.instant = scaled_rate(64'(tps_now), 64'd1, gap, sat);
                end
                meter_last = ts_in;
                if (meter_count != CNT_MAX) meter_count++;
                stamp_ring[meter_slot] = ts_in;
                meter_slot = (meter_slot + 1 == RING_DEPTH) ? 0 : meter_slot + 1;
            end
            KIND_QUERY: begin
                if (win_in != '0 && meter_count != '0) begin
                    span       = t_ts'(win_in) * t_ts'(tps_now);
                    scan_floor = (ts_in >= span) ? ts_in - span : '0;
                    if (ts_in < span || scan_floor < meter_start) scan_floor = meter_start;
                    n_scan = (meter_count < RING_DEPTH) ? meter_count : RING_DEPTH;
                    idx    = meter_slot;
                    hits   = 0;
                    for (int i = 0; i < n_scan; i++) begin
                        idx = (idx == 0) ? RING_DEPTH - 1 : idx - 1;
                        if (stamp_ring[idx] <= scan_floor) break;
                        hits++;
                    end
                    // divisor runs to the last entry visited, stop entry included
                    oldest_gap = ts_in - stamp_ring[idx];
                    r.windowed = scaled_rate(64'(hits), 64'(tps_now), oldest_gap, sat);
                end
                if (meter_count != '0) begin
                    gap     = ts_in - meter_start;
                    r.total = scaled_rate(64'(meter_count), 64'(tps_now), gap, sat);
                end
            end
            KIND_RESTART: begin
                meter_start = ts_in;
                meter_last  = ts_in;
                meter_count = '0;
                meter_slot  = 0;
            end
            default: begin
            end
        endcase
        r.saturated = sat;
        pending_results.push_back(r);
    endfunction

    task automatic send_request(input t_kind kind_in, input t_ts ts_in, input t_win win_in);
        int unsigned gap;
        gap = idle_draw();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.kind           <= kind_in;
        in_if.timestamp      <= ts_in;
        in_if.window_seconds <= win_in;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        predict_rates(kind_in, ts_in, win_in);
        items_sent++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // call only with the meter idle
    task automatic write_tps(input t_tps value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TPS_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tps_now = value;
    endtask

    task automatic check_result();
        t_rate_result e;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, kind %0d",
                                      out_if.done_kind));
            return;
        end
        e = pending_results.pop_front();
        if (out_if.done_kind !== e.kind)
            report_mismatch($sformatf("done_kind %0d, want %0d", out_if.done_kind, e.kind));
        if (out_if.instant_rate !== e.instant)
            report_mismatch($sformatf("instant_rate %h, want %h", out_if.instant_rate,
                                      e.instant));
        if (out_if.instant_infinite !== e.infinite)
            report_mismatch($sformatf("instant_infinite %b, want %b",
                                      out_if.instant_infinite, e.infinite));
        if (out_if.window_rate !== e.windowed)
            report_mismatch($sformatf("window_rate %h, want %h", out_if.window_rate,
                                      e.windowed));
        if (out_if.total_rate !== e.total)
            report_mismatch($sformatf("total_rate %h, want %h", out_if.total_rate, e.total));
        if (out_if.rate_saturated !== e.saturated)
            report_mismatch($sformatf("rate_saturated %b, want %b", out_if.rate_saturated,
                                      e.saturated));
    endtask

    // result side: random stalls per result plus an optional long hold-off
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                check_result();
                stall_left = idle_draw();
            end
            if (out_hold_cycles > 0) begin
                out_hold_cycles--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_request(KIND_QUERY, 48'd500, 16'd5);
        send_request(KIND_EVENT, 48'd0, 16'd0);
        send_request(KIND_EVENT, 48'd0, 16'd0);
        send_request(KIND_EVENT, 48'd1, 16'd0);
        send_request(KIND_EVENT, 48'd250000, 16'd0);
        send_request(KIND_EVENT, STAMP_MAX, 16'hFFFF);
        send_request(KIND_EVENT, 48'd500000, 16'd0);
        send_request(KIND_QUERY, 48'd500000, 16'd0);
        send_request(KIND_QUERY, 48'd500000, 16'd1);
        send_request(KIND_QUERY, 48'd500000, 16'hFFFF);
        send_request(KIND_QUERY, STAMP_MAX, 16'hFFFF);
        send_request(KIND_RESTART, 48'd1000, 16'd0);
        send_request(KIND_QUERY, 48'd1000, 16'd3);
        send_request(KIND_EVENT, 48'd1000, 16'd0);
        // window stops on its first entry and both divisors are zero
        send_request(KIND_QUERY, 48'd1000, 16'd1);
        send_request(KIND_EVENT, 48'd3000, 16'd0);
        send_request(KIND_EVENT, 48'd5000, 16'd0);
        send_request(KIND_QUERY, 48'd5000, 16'd1);
        send_request(KIND_UNUSED, rand_stamp(), t_win'($urandom));
        send_request(KIND_UNUSED, 48'd0, 16'd0);
        send_request(KIND_RESTART, STAMP_MAX, 16'd0);
        send_request(KIND_EVENT, 48'd0, 16'd0);
        send_request(KIND_QUERY, 48'd0, 16'hFFFF);
    endtask

    task automatic test_tps_extremes();
        drain_results();
        write_tps(t_tps'(1));
        send_request(KIND_RESTART, 48'd100, 16'd0);
        send_request(KIND_EVENT, 48'd100, 16'd0);
        send_request(KIND_EVENT, 48'd101, 16'd0);
        send_request(KIND_EVENT, 48'd101, 16'd0);
        send_request(KIND_EVENT, 48'd103, 16'd0);
        send_request(KIND_EVENT, 48'd110, 16'd0);
        send_request(KIND_QUERY, 48'd111, 16'd2);
        drain_results();
        write_tps(TPS_MAX);
        send_request(KIND_RESTART, 48'd0, 16'd0);
        // wrap the ring, then overflow the windowed rate
        for (int i = 1; i <= 70; i++) send_request(KIND_EVENT, t_ts'(i), 16'd0);
        send_request(KIND_QUERY, 48'd70, 16'd1);
        send_request(KIND_QUERY, 48'd71, 16'd1);
        send_request(KIND_QUERY, 48'h8000_0000_0000, 16'hFFFF);
        drain_results();
        write_tps(TPS_RESET);
    endtask

    // sink holds off long enough that the meter backs up and stalls requests
    task automatic test_input_stall();
        drain_results();
        idle_on = 1'b0;
        out_hold_cycles = LONG_HOLD;
        send_request(KIND_RESTART, 48'd10_000_000, 16'd0);
        for (int i = 1; i <= 10; i++) begin
            if (i % 3 == 0)
                send_request(KIND_QUERY, t_ts'(10_000_000 + i * 300_000), 16'd2);
            else
                send_request(KIND_EVENT, t_ts'(10_000_000 + i * 300_000), 16'd0);
        end
        drain_results();
        idle_on = 1'b1;
    endtask

    function automatic t_win pick_window();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 30) return t_win'($urandom_range(1, 4));
        if (roll < 90) return t_win'($urandom_range(1, 40));
        return t_win'($urandom);
    endfunction

    task automatic test_random_traffic();
        t_tps        tps_pick;
        int unsigned shift;
        int unsigned n_items;
        int unsigned roll;
        logic [63:0] max_step;
        logic [63:0] tick_step;
        while (items_sent < ITEM_TARGET) begin
            drain_results();
            case ($urandom_range(0, 5))
                0:       tps_pick = t_tps'(1);
                1:       tps_pick = t_tps'($urandom_range(2, 100));
                2:       tps_pick = TPS_RESET;
                3:       tps_pick = t_tps'($urandom_range(1, 32'hFFFF_FFFF));
                4:       tps_pick = TPS_MAX;
                default: tps_pick = t_tps'($urandom_range(1000, 100000));
            endcase
            write_tps(tps_pick);
            idle_on   = ($urandom_range(0, 3) != 0);
            stamp_now = $urandom_range(0, 1) ? (rand_stamp() >> 1) : t_ts'($urandom_range(0, 999));
            shift     = $urandom_range(0, 5);
            max_step  = ((64'(tps_now) >> shift) | 64'd1) * 2;
            n_items   = $urandom_range(60, 200);
            send_request(KIND_RESTART, stamp_now, pick_window());
            for (int i = 0; i < n_items; i++) begin
                roll = $urandom_range(0, 99);
                tick_step = ($urandom_range(0, 9) == 0) ? 64'd0
                            : (64'($urandom) * max_step) >> 32;
                if (roll < 55) begin
                    stamp_now = stamp_now + t_ts'(tick_step);
                    send_request(KIND_EVENT, stamp_now, t_win'($urandom));
                end else if (roll < 88) begin
                    stamp_now = stamp_now + t_ts'(tick_step >> 2);
                    send_request(KIND_QUERY, stamp_now, pick_window());
                end else if (roll < 91) begin
                    send_request(KIND_RESTART, stamp_now, t_win'($urandom));
                end else if (roll < 94) begin
                    send_request(KIND_UNUSED, rand_stamp(), t_win'($urandom));
                end else begin
                    // noise: any kind at an arbitrary, possibly earlier, time
                    send_request(t_kind'($urandom_range(0, 3)), rand_stamp(),
                                 t_win'($urandom));
                end
            end
        end
    endtask

    initial begin
        in_if.valid          <= 1'b0;
        in_if.kind           <= KIND_EVENT;
        in_if.timestamp      <= '0;
        in_if.window_seconds <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        rst_n                <= 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        out_hold_cycles = 0;
        idle_on         = 1'b1;
        stamp_now       = '0;
        reset_meter();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_tps_extremes();
        test_input_stall();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
